/* sv/polyprod_pkg.sv */
package polyprod_pkg;

	// Coefficient format and default sizing
	localparam int COEF_W        = 32;
	localparam int PROD_W        = 2 * COEF_W;
	localparam int MAX_TERMS_DEF = 64;
	localparam int FRAC_BITS_DEF = 16;

	localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
	localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

	// Accumulator width: one shifted product plus growth over max_terms sums
	function automatic int acc_width(input int max_terms, input int frac_bits);
		return PROD_W - frac_bits + $clog2(max_terms + 1);
	endfunction

	// Controls broadcast to every cell of the ring
	typedef struct packed {
		logic                     p_shift;
		logic                     acc_shift;
		logic                     load;
		logic                     acc_clr;
		logic signed [COEF_W-1:0] seed;
	} cell_ctl_t;

endpackage

/* sv/polyprod_cell.sv */
module polyprod_cell #(
	parameter int ACC_W = polyprod_pkg::acc_width(polyprod_pkg::MAX_TERMS_DEF,
		polyprod_pkg::FRAC_BITS_DEF)
) (
	input  logic                                   clk,
	input  polyprod_pkg::cell_ctl_t                ctl,
	input  logic                                   seed_we,
	input  logic signed [polyprod_pkg::COEF_W-1:0] p_in,
	input  logic signed [ACC_W-1:0]                acc_in,
	input  logic                                   add_en,
	input  logic signed [ACC_W-1:0]                add_in,
	output logic signed [polyprod_pkg::COEF_W-1:0] p_out,
	output logic signed [ACC_W-1:0]                acc_out,
	output logic                                   sat
);
	import polyprod_pkg::*;

	logic signed [COEF_W-1:0] p_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [ACC_W-COEF_W:0]    upper;
	logic                     fits;
	logic signed [COEF_W-1:0] sat_val;

	// Clamp the accumulated term to the coefficient range
	always_comb begin
		upper   = acc_q[ACC_W-1:COEF_W-1];
		fits    = (&upper) | (~|upper);
		sat     = !fits;
		if (fits) begin
			sat_val = acc_q[COEF_W-1:0];
		end else if (acc_q[ACC_W-1]) begin
			sat_val = COEF_MIN;
		end else begin
			sat_val = COEF_MAX;
		end
	end

	// Product term: seed, load from accumulator, or pass along the ring
	always_ff @(posedge clk) begin
		if (seed_we) begin
			p_q <= ctl.seed;
		end else if (ctl.load) begin
			p_q <= sat_val;
		end else if (ctl.p_shift) begin
			p_q <= p_in;
		end
	end

	// Accumulator: clear, or pass along the ring and add the MAC result here
	always_ff @(posedge clk) begin
		if (ctl.acc_clr || ctl.load) begin
			acc_q <= '0;
		end else if (ctl.acc_shift) begin
			acc_q <= add_en ? (acc_in + add_in) : acc_in;
		end
	end

	assign p_out   = p_q;
	assign acc_out = acc_q;

endmodule

/* sv/polyprod_mac.sv */
module polyprod_mac #(
	parameter int FRAC_BITS = polyprod_pkg::FRAC_BITS_DEF,
	parameter int ACC_W     = polyprod_pkg::acc_width(polyprod_pkg::MAX_TERMS_DEF,
		polyprod_pkg::FRAC_BITS_DEF)
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic signed [polyprod_pkg::COEF_W-1:0] a,
	input  logic signed [polyprod_pkg::COEF_W-1:0] b,
	output logic                                   add_en,
	output logic signed [ACC_W-1:0]                addend
);
	import polyprod_pkg::*;

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [PROD_W-1:0] shifted;
	logic                     en_s1;

	// Register the full product
	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(a) * PROD_W'(b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1 <= 1'b0;
		end else begin
			en_s1 <= en;
		end
	end

	// Drop fraction bits, rounding toward minus infinity
	assign shifted = prod_s1 >>> FRAC_BITS;
	assign addend  = ACC_W'(shifted);
	assign add_en  = en_s1;

endmodule

/* sv/polynomial_product.sv */
// A first-polynomial coefficient is written straight into the ring; a later-polynomial one is
// multiplied against every stored term in one pass around the ring.
// Closing a later polynomial realigns the ring and then loads the clamped terms.
// After end of set, leading zeros are skipped, then one result per cycle is output.
// Results cannot be stalled; each is strobed for one cycle. Reset clears control state only;
// the coefficient ring holds no valid data until written.
module polynomial_product #(
	parameter int MAX_TERMS = polyprod_pkg::MAX_TERMS_DEF,
	parameter int FRAC_BITS = polyprod_pkg::FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic signed [polyprod_pkg::COEF_W-1:0] coefficient,
	input  logic                                   end_of_polynomial,
	input  logic                                   end_of_set,
	output logic                                   result_strobe,
	output logic signed [polyprod_pkg::COEF_W-1:0] product_coefficient,
	output logic                                   last,
	output logic                                   overflow
);
	import polyprod_pkg::*;

	localparam int LEN_W = $clog2(MAX_TERMS + 1);
	localparam int IDX_W = $clog2(MAX_TERMS);
	localparam int ACC_W = acc_width(MAX_TERMS, FRAC_BITS);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TERMS);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_TERMS - 1);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SWEEP  = 5'b00010,
		S_FINISH = 5'b00100,
		S_SKIP   = 5'b01000,
		S_EMIT   = 5'b10000
	} state_t;

	state_t                   state_q;
	logic [LEN_W-1:0]         op_len_q;
	logic [LEN_W-1:0]         n_q;
	logic [LEN_W-1:0]         t_q;
	logic [IDX_W-1:0]         ofs_q;
	logic                     awaiting_q;
	logic                     ovf_q;
	logic                     fin_q;
	logic                     eos_q;
	logic signed [COEF_W-1:0] coef_q;
	logic                     strobe_q;
	logic signed [COEF_W-1:0] out_coef_q;
	logic                     last_q;
	logic                     out_ovf_q;

	cell_ctl_t                ctl;
	logic                     accept;
	logic                     stored;
	logic                     seed_en;
	logic                     mul_en;
	logic                     mac_add_en;
	logic signed [ACC_W-1:0]  mac_addend;
	logic signed [COEF_W-1:0] head;
	logic [IDX_W-1:0]         ofs_next;
	logic [LEN_W:0]           full;
	logic [LEN_W-1:0]         keep;
	logic                     trunc;
	logic                     t_last;

	logic signed [COEF_W-1:0] p_out   [MAX_TERMS];
	logic signed [ACC_W-1:0]  acc_out [MAX_TERMS];
	logic [MAX_TERMS-1:0]     sat_vec;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign stored = (op_len_q != LEN_MAX);
	assign head   = p_out[0];

	assign ofs_next = (ofs_q == IDX_LAST) ? '0 : ofs_q + IDX_W'(1);
	assign full     = {1'b0, n_q} + {1'b0, op_len_q} - (LEN_W+1)'(1);
	assign trunc    = (full > (LEN_W+1)'(MAX_TERMS));
	assign keep     = trunc ? LEN_MAX : full[LEN_W-1:0];
	assign t_last   = ((t_q + LEN_W'(1)) == n_q);

	// Drive the ring controls for the current phase
	always_comb begin
		ctl       = '0;
		ctl.seed  = coefficient;
		seed_en   = 1'b0;
		mul_en    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && stored && awaiting_q) begin
					seed_en     = 1'b1;
					ctl.acc_clr = 1'b1;
				end
			end
			S_SWEEP: begin
				ctl.p_shift   = (t_q != LEN_MAX);
				ctl.acc_shift = 1'b1;
				mul_en        = (t_q != LEN_MAX) && (t_q < n_q) &&
					(({1'b0, t_q} + (LEN_W+1)'(ofs_q)) < (LEN_W+1)'(MAX_TERMS));
			end
			S_FINISH: begin
				if (!awaiting_q) begin
					if (ofs_q != '0) begin
						ctl.acc_shift = 1'b1;
					end else begin
						ctl.load = 1'b1;
					end
				end
			end
			S_SKIP: begin
				ctl.p_shift = (t_q != n_q);
			end
			S_EMIT: begin
				ctl.p_shift = 1'b1;
			end
			default: begin
				ctl.p_shift = 1'b0;
			end
		endcase
	end

	// Ring of cells: product terms and accumulators both advance toward cell 0
	for (genvar c = 0; c < MAX_TERMS; c++) begin : g_cell
		localparam int NXT = (c + 1) % MAX_TERMS;
		logic                    we;
		logic                    add_here;
		logic signed [ACC_W-1:0] add_val;

		assign we       = seed_en && (op_len_q == LEN_W'(c));
		assign add_here = (c == MAX_TERMS - 2) ? mac_add_en : 1'b0;
		assign add_val  = (c == MAX_TERMS - 2) ? mac_addend : '0;

		polyprod_cell #(
			.ACC_W(ACC_W)
		) u_cell (
			.clk    (clk),
			.ctl    (ctl),
			.seed_we(we),
			.p_in   (p_out[NXT]),
			.acc_in (acc_out[NXT]),
			.add_en (add_here),
			.add_in (add_val),
			.p_out  (p_out[c]),
			.acc_out(acc_out[c]),
			.sat    (sat_vec[c])
		);
	end

	// Shared multiplier on the ring head; its sum lands one cell behind
	polyprod_mac #(
		.FRAC_BITS(FRAC_BITS),
		.ACC_W    (ACC_W)
	) u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (mul_en),
		.a     (head),
		.b     (coef_q),
		.add_en(mac_add_en),
		.addend(mac_addend)
	);

	// Hold the incoming coefficient for the sweep
	always_ff @(posedge clk) begin
		if (accept) begin
			coef_q <= coefficient;
		end
	end

	// Sequence transactions, convolution passes and result output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			op_len_q   <= '0;
			n_q        <= '0;
			t_q        <= '0;
			ofs_q      <= '0;
			awaiting_q <= 1'b1;
			ovf_q      <= 1'b0;
			fin_q      <= 1'b0;
			eos_q      <= 1'b0;
			strobe_q   <= 1'b0;
			out_coef_q <= '0;
			last_q     <= 1'b0;
			out_ovf_q  <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						fin_q <= end_of_polynomial || end_of_set;
						eos_q <= end_of_set;
						if (stored) begin
							op_len_q <= op_len_q + LEN_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (stored && awaiting_q) begin
							ofs_q <= '0;
						end
						if (stored && !awaiting_q) begin
							state_q <= S_SWEEP;
							t_q     <= '0;
						end else if (end_of_polynomial || end_of_set) begin
							state_q <= S_FINISH;
						end
					end
				end
				S_SWEEP: begin
					if (t_q == LEN_MAX) begin
						t_q     <= '0;
						ofs_q   <= ofs_next;
						state_q <= fin_q ? S_FINISH : S_IDLE;
					end else begin
						t_q <= t_q + LEN_W'(1);
					end
				end
				S_FINISH: begin
					if (awaiting_q) begin
						n_q        <= op_len_q;
						awaiting_q <= 1'b0;
						op_len_q   <= '0;
						t_q        <= '0;
						state_q    <= eos_q ? S_SKIP : S_IDLE;
					end else if (ofs_q != '0) begin
						ofs_q <= ofs_next;
					end else begin
						n_q      <= keep;
						ovf_q    <= ovf_q || (|sat_vec) || trunc;
						op_len_q <= '0;
						t_q      <= '0;
						state_q  <= eos_q ? S_SKIP : S_IDLE;
					end
				end
				S_SKIP: begin
					if (t_q == n_q) begin
						// All-zero product: emit one zero
						strobe_q   <= 1'b1;
						out_coef_q <= '0;
						last_q     <= 1'b1;
						out_ovf_q  <= ovf_q;
						n_q        <= '0;
						op_len_q   <= '0;
						awaiting_q <= 1'b1;
						ovf_q      <= 1'b0;
						state_q    <= S_IDLE;
					end else if (head != '0) begin
						strobe_q   <= 1'b1;
						out_coef_q <= head;
						last_q     <= t_last;
						out_ovf_q  <= ovf_q;
						t_q        <= t_q + LEN_W'(1);
						if (t_last) begin
							n_q        <= '0;
							op_len_q   <= '0;
							awaiting_q <= 1'b1;
							ovf_q      <= 1'b0;
							state_q    <= S_IDLE;
						end else begin
							state_q <= S_EMIT;
						end
					end else begin
						t_q <= t_q + LEN_W'(1);
					end
				end
				S_EMIT: begin
					strobe_q   <= 1'b1;
					out_coef_q <= head;
					last_q     <= t_last;
					out_ovf_q  <= ovf_q;
					t_q        <= t_q + LEN_W'(1);
					if (t_last) begin
						n_q        <= '0;
						op_len_q   <= '0;
						awaiting_q <= 1'b1;
						ovf_q      <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_strobe       = strobe_q;
	assign product_coefficient = out_coef_q;
	assign last                = last_q;
	assign overflow            = out_ovf_q;

endmodule

/* dv/polyprod_checker.sv */
// Watches the coefficient and product channels of polynomial_product, keeps its own
// running product and compares every strobed product term against it.
module polyprod_checker #(
	parameter int MAX_TERMS = polyprod_pkg::MAX_TERMS_DEF,
	parameter int FRAC_BITS = polyprod_pkg::FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic                                   busy,
	input  logic signed [polyprod_pkg::COEF_W-1:0] coefficient,
	input  logic                                   end_of_polynomial,
	input  logic                                   end_of_set,
	input  logic                                   result_strobe,
	input  logic signed [polyprod_pkg::COEF_W-1:0] product_coefficient,
	input  logic                                   last,
	input  logic                                   overflow,
	output int                                     mismatches,
	output int                                     pending,
	output int                                     terms_checked,
	output int                                     flagged_sets
);

	import polyprod_pkg::*;

	typedef logic signed [COEF_W-1:0] coef_t;

	typedef struct {
		coef_t value;
		logic  last;
		logic  ovf;
	} term_t;

	// Running product and the polynomial being collected, lowest index = highest degree
	coef_t       running_product [MAX_TERMS];
	coef_t       incoming_poly [MAX_TERMS];
	int unsigned product_len;
	int unsigned poly_len;
	bit          seeding;
	bit          clipped;

	term_t expected_terms[$];

	// Clamp an exact term sum to the coefficient range, noting saturation
	function automatic coef_t clamp_sum(longint sum);
		if (sum > longint'(COEF_MAX)) begin
			clipped = 1'b1;
			return COEF_MAX;
		end
		if (sum < longint'(COEF_MIN)) begin
			clipped = 1'b1;
			return COEF_MIN;
		end
		return coef_t'(sum);
	endfunction

	// Convolve the collected polynomial into the running product
	function automatic void convolve_poly();
		coef_t       next_product [MAX_TERMS];
		int unsigned keep;
		int unsigned k;
		int unsigned i;
		int unsigned j;
		longint      sum;
		longint      term;
		keep = product_len + poly_len - 1;
		if (keep > MAX_TERMS) begin
			keep = MAX_TERMS;
			clipped = 1'b1;
		end
		for (k = 0; k < keep; k++) begin
			sum = 0;
			for (i = 0; i <= k && i < product_len; i++) begin
				j = k - i;
				if (j < poly_len) begin
					term = longint'(running_product[i]) * longint'(incoming_poly[j]);
					sum += term >>> FRAC_BITS;
				end
			end
			next_product[k] = clamp_sum(sum);
		end
		for (k = 0; k < keep; k++)
			running_product[k] = next_product[k];
		product_len = keep;
	endfunction

	// Take one accepted coefficient; queue the product terms at the end of a set
	function automatic void absorb_coefficient(coef_t c, logic eop, logic eos);
		int unsigned lead;
		int unsigned k;
		term_t       t;
		if (poly_len < MAX_TERMS) begin
			incoming_poly[poly_len] = c;
			poly_len++;
		end else begin
			clipped = 1'b1;
		end
		if (!(eop || eos))
			return;

		if (seeding) begin
			for (k = 0; k < poly_len; k++)
				running_product[k] = incoming_poly[k];
			product_len = poly_len;
			seeding = 1'b0;
		end else begin
			convolve_poly();
		end
		poly_len = 0;
		if (!eos)
			return;

		// Drop leading zeros; an all-zero product still yields one zero term
		lead = 0;
		while (lead < product_len && running_product[lead] == '0)
			lead++;
		t.ovf = clipped;
		if (lead >= product_len) begin
			t.value = '0;
			t.last  = 1'b1;
			expected_terms.insert(expected_terms.size(), t);
		end else begin
			for (k = lead; k < product_len; k++) begin
				t.value = running_product[k];
				t.last  = (k + 1 == product_len);
				expected_terms.insert(expected_terms.size(), t);
			end
		end
		if (clipped)
			flagged_sets++;

		product_len = 0;
		seeding     = 1'b1;
		clipped     = 1'b0;
	endfunction

	// Compare strobed terms first, then predict from the accepted transaction
	always @(posedge clk) begin : track_products
		term_t want;
		if (!arst_n) begin
			expected_terms.delete();
			product_len   = 0;
			poly_len      = 0;
			seeding       = 1'b1;
			clipped       = 1'b0;
			mismatches    = 0;
			terms_checked = 0;
			flagged_sets  = 0;
		end else begin
			if (result_strobe) begin
				if (expected_terms.size() == 0) begin
					$display("%0t: unexpected product term %0d last %0b overflow %0b",
						$time, product_coefficient, last, overflow);
					mismatches++;
				end else begin
					want = expected_terms.pop_front();
					terms_checked++;
					if (product_coefficient !== want.value || last !== want.last ||
						overflow !== want.ovf) begin
						$display("%0t: product term mismatch: expected %0d last %0b overflow %0b",
							$time, want.value, want.last, want.ovf);
						$display("%0t:                          actual %0d last %0b overflow %0b",
							$time, product_coefficient, last, overflow);
						mismatches++;
					end
				end
			end
			if (start && !busy)
				absorb_coefficient(coefficient, end_of_polynomial, end_of_set);
		end
		pending = expected_terms.size();
	end

endmodule

/* dv/tb_polynomial_product.sv */
module tb_polynomial_product;

	import polyprod_pkg::*;

	typedef logic signed [COEF_W-1:0] coef_t;

	localparam int    CYCLE_LIMIT  = 500000;
	localparam int    RANDOM_ITEMS = 250;
	localparam int    QUIET_TAIL   = 40;
	localparam coef_t Q_ONE        = coef_t'(1 << FRAC_BITS_DEF);

	logic  clk               = 1'b0;
	logic  arst_n            = 1'b0;
	logic  start             = 1'b0;
	coef_t coefficient       = '0;
	logic  end_of_polynomial = 1'b0;
	logic  end_of_set        = 1'b0;
	logic  busy;
	logic  result_strobe;
	coef_t product_coefficient;
	logic  last;
	logic  overflow;

	int mismatches;
	int pending;
	int terms_checked;
	int flagged_sets;
	int coefs_sent  = 0;
	int sets_sent   = 0;
	int quiet_from  = 0;
	int cycle_count = 0;
	bit gaps_on     = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	polynomial_product u_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.start               (start),
		.busy                (busy),
		.coefficient         (coefficient),
		.end_of_polynomial   (end_of_polynomial),
		.end_of_set          (end_of_set),
		.result_strobe       (result_strobe),
		.product_coefficient (product_coefficient),
		.last                (last),
		.overflow            (overflow)
	);

	polyprod_checker u_checker (
		.clk                 (clk),
		.arst_n              (arst_n),
		.start               (start),
		.busy                (busy),
		.coefficient         (coefficient),
		.end_of_polynomial   (end_of_polynomial),
		.end_of_set          (end_of_set),
		.result_strobe       (result_strobe),
		.product_coefficient (product_coefficient),
		.last                (last),
		.overflow            (overflow),
		.mismatches          (mismatches),
		.pending             (pending),
		.terms_checked       (terms_checked),
		.flagged_sets        (flagged_sets)
	);

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d product terms outstanding",
				cycle_count, pending);
			$display("polynomial_product verification failed");
			$finish;
		end
	end

	// Half small Q16.16 values, the rest zeros, extremes and full-range noise
	function automatic coef_t pick_coef();
		coef_t c;
		int    whole;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: begin
				whole = int'($urandom_range(0, 8)) - 4;
				c = coef_t'(whole * (1 << FRAC_BITS_DEF) + int'($urandom_range(0, 65535)));
			end
			5: c = '0;
			6: begin
				case ($urandom_range(0, 3))
					0:       c = COEF_MAX;
					1:       c = COEF_MIN;
					2:       c = coef_t'(1);
					default: c = coef_t'(-1);
				endcase
			end
			default: c = coef_t'($urandom);
		endcase
		return c;
	endfunction

	// Issue one coefficient transaction, optionally after an idle burst
	task automatic send_coef(coef_t c, logic eop, logic eos);
		if (gaps_on && coefs_sent < quiet_from && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		start             <= 1'b1;
		coefficient       <= c;
		end_of_polynomial <= eop;
		end_of_set        <= eos;
		do @(posedge clk); while (busy);
		coefs_sent++;
		if (eos)
			sets_sent++;
	endtask

	// Send one polynomial; a set closer sometimes omits its end-of-polynomial mark
	task automatic send_poly(int len, logic closes, bit zero_fill);
		coef_t c;
		bit    drop_eop;
		int    t;
		for (t = 0; t < len; t++) begin
			c = zero_fill ? coef_t'(0) : pick_coef();
			drop_eop = closes && ($urandom_range(0, 9) == 0);
			if (t == len - 1)
				send_coef(c, !drop_eop, closes);
			else
				send_coef(c, 1'b0, 1'b0);
		end
	endtask

	task automatic send_random_set(int polys, int max_len);
		int p;
		int len;
		for (p = 0; p < polys; p++) begin
			len = $urandom_range(1, max_len);
			// lead with a zero now and then so leading-zero stripping gets hit
			if (p == 0 && len > 1 && $urandom_range(0, 5) == 0) begin
				send_coef('0, 1'b0, 1'b0);
				len--;
			end
			send_poly(len, p == polys - 1, $urandom_range(0, 19) == 0);
		end
	endtask

	initial begin
		int set_idx;
		int span_a;
		int span_b;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		quiet_from = CYCLE_LIMIT;
		gaps_on    = 1'b1;

		// one-polynomial sets: largest value, a zero product, leading zeros
		send_coef(COEF_MAX, 1'b1, 1'b1);
		send_coef('0, 1'b1, 1'b1);
		send_coef('0, 1'b0, 1'b0);
		send_coef('0, 1'b0, 1'b0);
		send_coef(coef_t'(3) * Q_ONE, 1'b1, 1'b1);
		// positive and negative saturation
		send_coef(COEF_MAX, 1'b1, 1'b0);
		send_coef(COEF_MAX, 1'b1, 1'b1);
		send_coef(COEF_MIN, 1'b1, 1'b0);
		send_coef(COEF_MAX, 1'b0, 1'b0);
		send_coef(COEF_MIN, 1'b1, 1'b1);
		// shift rounds toward minus infinity
		send_coef(coef_t'(-1), 1'b1, 1'b0);
		send_coef(coef_t'(1), 1'b1, 1'b1);
		// unequal lengths, set closed without end of polynomial
		send_coef(Q_ONE, 1'b0, 1'b0);
		send_coef(-coef_t'(2) * Q_ONE, 1'b0, 1'b0);
		send_coef(Q_ONE >>> 1, 1'b1, 1'b0);
		send_coef(coef_t'(3) * Q_ONE, 1'b0, 1'b0);
		send_coef(Q_ONE >>> 2, 1'b1, 1'b0);
		send_coef(-Q_ONE, 1'b0, 1'b1);
		// all-zero product from a zero factor
		send_coef(Q_ONE, 1'b0, 1'b0);
		send_coef(Q_ONE, 1'b1, 1'b0);
		send_coef('0, 1'b1, 1'b1);
		// later polynomial closed by end of set on its first coefficient
		send_coef(coef_t'(2) * Q_ONE, 1'b1, 1'b0);
		send_coef(coef_t'(5), 1'b0, 1'b1);

		// random sets, with one oversized polynomial and one oversized product
		quiet_from = coefs_sent + RANDOM_ITEMS - QUIET_TAIL;
		span_b     = coefs_sent + RANDOM_ITEMS;
		set_idx    = 0;
		while (coefs_sent < span_b) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			if (set_idx == 2) begin
				send_poly($urandom_range(MAX_TERMS_DEF + 1, MAX_TERMS_DEF + 4), 1'b1, 1'b0);
			end else if (set_idx == 5) begin
				span_a = $urandom_range(30, 34);
				send_poly(span_a, 1'b0, 1'b0);
				send_poly(MAX_TERMS_DEF + 2 - span_a + $urandom_range(0, 3), 1'b1, 1'b0);
			end else begin
				send_random_set($urandom_range(1, 4), $urandom_range(1, 6));
			end
			set_idx++;
		end
		start <= 1'b0;

		// drain the product terms still owed, then let the block settle
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (2 * MAX_TERMS_DEF + 8) @(posedge clk);

		$display("run sent %0d coefficients in %0d polynomial sets", coefs_sent, sets_sent);
		$display("%0d product terms compared, %0d sets raised overflow",
			terms_checked, flagged_sets);
		if (mismatches == 0 && pending == 0) begin
			$display("polynomial_product verification clean");
		end else begin
			$display("polynomial_product verification failed");
		end
		$finish;
	end

endmodule

/* filelist.f */
sv/polyprod_pkg.sv
sv/polyprod_cell.sv
sv/polyprod_mac.sv
sv/polynomial_product.sv
dv/polyprod_checker.sv
dv/tb_polynomial_product.sv
